// ===== hdl/psfl_pkg.sv =====
// Shared types and constants for the power safety fault latch.
// Standalone package; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps

package psfl_pkg;

   localparam int CUR_W       = 16;   // signed current, mA
   localparam int BUS_W       = 15;   // unsigned bus voltage, mV
   localparam int LIM_W       = 15;   // configuration register width
   localparam int CMP_W       = CUR_W + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;

   localparam int EMA_SHIFT_DEF     = 6;
   localparam int AVG_FRAC_BITS_DEF = 8;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [LIM_W-1:0] CURRENT_LIMIT_RST   = 15'd2000;
   localparam logic [LIM_W-1:0] BUS_MIN_RST         = 15'd4500;
   localparam logic [LIM_W-1:0] AVG_CURRENT_LIM_RST = 15'd1500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURRENT_LIMIT = 2'd0,
      CSR_BUS_MIN       = 2'd1,
      CSR_AVG_LIMIT     = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_ESTOP  = 2'd1,
      CMD_ARM    = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      FAULT_NONE        = 2'd0,
      FAULT_OVERCURRENT = 2'd1,
      FAULT_UNDERVOLT   = 2'd2,
      FAULT_ESTOP       = 2'd3
   } fault_type;

   // Classified command as it sits in the queue between front and back.
   typedef struct packed {
      cmd_type                  cmd;
      logic signed [CUR_W-1:0]  current;
      logic                     inst_oc;  // sample above the instantaneous limit
      logic                     bus_uv;   // nonzero bus below its minimum
   } item_type;

endpackage

// ===== hdl/psfl_front.sv =====
// Front end: configuration registers, input acceptance and classification.
// Depends on psfl_pkg; pushes classified commands into psfl_queue.
`timescale 1ns / 1ps

module psfl_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [psfl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psfl_pkg::LIM_W-1:0]         csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [psfl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               queue_full,
   output logic                               push_valid,
   output psfl_pkg::item_type                 push_item,
   output logic [psfl_pkg::LIM_W-1:0]         avg_limit
);

   logic [psfl_pkg::LIM_W-1:0] cur_limit_ff, cur_limit_in;
   logic [psfl_pkg::LIM_W-1:0] bus_min_ff, bus_min_in;
   logic [psfl_pkg::LIM_W-1:0] avg_limit_ff, avg_limit_in;
   logic                       csr_write;
   logic signed [psfl_pkg::CUR_W-1:0] current;
   logic [psfl_pkg::BUS_W-1:0]        bus_mv;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cur_limit_in = cur_limit_ff;
      bus_min_in   = bus_min_ff;
      avg_limit_in = avg_limit_ff;
      if (csr_write) begin
         case (psfl_pkg::csr_index_type'(csr_index))
            psfl_pkg::CSR_CURRENT_LIMIT: cur_limit_in = csr_data;
            psfl_pkg::CSR_BUS_MIN:       bus_min_in   = csr_data;
            psfl_pkg::CSR_AVG_LIMIT:     avg_limit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_limit_ff <= psfl_pkg::CURRENT_LIMIT_RST;
         bus_min_ff   <= psfl_pkg::BUS_MIN_RST;
         avg_limit_ff <= psfl_pkg::AVG_CURRENT_LIM_RST;
      end else begin
         cur_limit_ff <= cur_limit_in;
         bus_min_ff   <= bus_min_in;
         avg_limit_ff <= avg_limit_in;
      end
   end

   assign avg_limit = avg_limit_ff;

   assign current = req_tdata[psfl_pkg::CUR_W-1:0];
   assign bus_mv  = req_tdata[psfl_pkg::CUR_W +: psfl_pkg::BUS_W];

   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && req_tready;

   always_comb begin
      push_item.cmd     = psfl_pkg::cmd_type'(req_tuser);
      push_item.current = current;
      push_item.inst_oc = $signed({current[psfl_pkg::CUR_W-1], current})
                          > $signed({2'b00, cur_limit_ff});
      push_item.bus_uv  = (bus_mv != '0) && (bus_mv < bus_min_ff);
   end

endmodule

// ===== hdl/psfl_queue.sv =====
// Short FIFO of classified commands between the front and back ends.
// Depends on psfl_pkg for the entry type and depth.
`timescale 1ns / 1ps

module psfl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  psfl_pkg::item_type  push_item,
   output logic                full,
   output logic                pop_valid,
   output psfl_pkg::item_type  pop_item,
   input  logic                pop
);

   localparam int DEPTH = psfl_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   psfl_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/psfl_back.sv =====
// Back end: fault latch, servo/LED state, current average and response register.
// Depends on psfl_pkg; drains psfl_queue one command per cycle unless rsp stalls.
`timescale 1ns / 1ps

module psfl_back #(
   parameter int EMA_SHIFT     = psfl_pkg::EMA_SHIFT_DEF,
   parameter int AVG_FRAC_BITS = psfl_pkg::AVG_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  psfl_pkg::item_type               item,
   output logic                             item_pop,
   input  logic [psfl_pkg::LIM_W-1:0]       avg_limit,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [psfl_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CUR_W  = psfl_pkg::CUR_W;
   localparam int AVG_W  = CUR_W + AVG_FRAC_BITS;
   localparam int DIFF_W = AVG_W + 1;

   psfl_pkg::fault_type      fault_ff, fault_in;
   logic signed [AVG_W-1:0]  avg_ff, avg_in;
   logic signed [CUR_W-1:0]  last_ff, last_in;
   logic                     servo_ff, servo_in;
   logic                     led_ff, led_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [psfl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [DIFF_W-1:0] x_wide, diff, step;
   logic signed [AVG_W-1:0]  avg_new;
   logic signed [CUR_W-1:0]  avg_int_new, avg_int_old, avg_int_out;
   logic                     avg_oc;
   logic                     trip_req, trip, oc_event, refused, is_sample;
   psfl_pkg::fault_type      trip_code;

   assign item_pop = item_valid && (!rsp_valid_ff || rsp_tready);

   // avg += floor((x - avg) / 2^EMA_SHIFT), x = current scaled to the fraction bits
   assign x_wide      = DIFF_W'(item.current) <<< AVG_FRAC_BITS;
   assign diff        = x_wide - DIFF_W'(avg_ff);
   assign step        = diff >>> EMA_SHIFT;
   assign avg_new     = avg_ff + AVG_W'(step);
   assign avg_int_new = avg_new[AVG_W-1:AVG_FRAC_BITS];
   assign avg_int_old = avg_ff[AVG_W-1:AVG_FRAC_BITS];
   assign avg_oc      = $signed({avg_int_new[CUR_W-1], avg_int_new})
                        > $signed({2'b00, avg_limit});

   always_comb begin
      trip_req  = 1'b0;
      trip_code = psfl_pkg::FAULT_NONE;
      oc_event  = 1'b0;
      refused   = 1'b0;
      is_sample = 1'b0;
      fault_in  = fault_ff;
      servo_in  = servo_ff;
      led_in    = led_ff;
      case (item.cmd)
         psfl_pkg::CMD_SAMPLE: begin
            is_sample = 1'b1;
            if (item.inst_oc) begin
               oc_event  = 1'b1;
               trip_req  = 1'b1;
               trip_code = psfl_pkg::FAULT_OVERCURRENT;
            end else if (item.bus_uv) begin
               trip_req  = 1'b1;
               trip_code = psfl_pkg::FAULT_UNDERVOLT;
            end else if (avg_oc) begin
               trip_req  = 1'b1;
               trip_code = psfl_pkg::FAULT_OVERCURRENT;
            end
         end
         psfl_pkg::CMD_ESTOP: begin
            trip_req  = 1'b1;
            trip_code = psfl_pkg::FAULT_ESTOP;
         end
         psfl_pkg::CMD_ARM: begin
            if (fault_ff != psfl_pkg::FAULT_NONE) begin
               refused = 1'b1;
            end else begin
               servo_in = 1'b1;
            end
         end
         psfl_pkg::CMD_CLEAR: begin
            if (fault_ff == psfl_pkg::FAULT_ESTOP) begin
               refused = 1'b1;
            end else begin
               fault_in = psfl_pkg::FAULT_NONE;
               led_in   = 1'b0;
            end
         end
         default: ;
      endcase
      // only the first fault is latched
      trip = trip_req && (fault_ff == psfl_pkg::FAULT_NONE);
      if (trip) begin
         fault_in = trip_code;
         servo_in = 1'b0;
         led_in   = 1'b1;
      end
   end

   assign last_in     = is_sample ? item.current : last_ff;
   assign avg_in      = is_sample ? avg_new : avg_ff;
   assign avg_int_out = is_sample ? avg_int_new : avg_int_old;

   always_comb begin
      rsp_data_in = {1'b0, avg_int_out, last_in, refused, led_in, servo_in,
                     oc_event, trip, fault_in};
      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff     <= psfl_pkg::FAULT_NONE;
         avg_ff       <= '0;
         last_ff      <= '0;
         servo_ff     <= 1'b0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            fault_ff <= fault_in;
            avg_ff   <= avg_in;
            last_ff  <= last_in;
            servo_ff <= servo_in;
            led_ff   <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/power_safety_fault_latch_top.sv =====
// Top level of the power safety fault latch: front end, command queue, back end.
// Depends on psfl_pkg, psfl_front, psfl_queue and psfl_back.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: current, bus_mv; tuser: command
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: fault_code .. avg_current
//   csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
// One command per cycle sustained while rsp_tready is high; a response passes
// through a queue entry, then the response register. The combinational back-end
// update (average add/shift/compare and fault latch) sets the rate. Synchronous
// active-high reset clears all state but the queue entries and response data,
// and loads the default limits. A stalled response backs up into the two-entry
// queue; req_tready drops only when the queue is full. csr_ready is always high.
`timescale 1ns / 1ps

module power_safety_fault_latch_top #(
   parameter int EMA_SHIFT     = psfl_pkg::EMA_SHIFT_DEF,
   parameter int AVG_FRAC_BITS = psfl_pkg::AVG_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] current, [30:16] bus_mv, [31] zero
   input  logic [psfl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] command
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] fault_code, [2] trip_now, [3] overcurrent_event, [4] servo_enable,
   // [5] fault_led, [6] command_status, [22:7] last_current,
   // [38:23] avg_current, [39] zero
   output logic [psfl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psfl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psfl_pkg::LIM_W-1:0]       csr_data
);

   logic                       push_valid, queue_full, pop_valid, pop;
   psfl_pkg::item_type         push_item, pop_item;
   logic [psfl_pkg::LIM_W-1:0] avg_limit;

   psfl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item),
      .avg_limit  (avg_limit)
   );

   psfl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   psfl_back #(
      .EMA_SHIFT     (EMA_SHIFT),
      .AVG_FRAC_BITS (AVG_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .avg_limit  (avg_limit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/psfl_checker.sv =====
// Port-level checks on the fault latch responses, bound to the top level.
// Depends on psfl_pkg and power_safety_fault_latch_top.
`timescale 1ns / 1ps

module psfl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [psfl_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // LED is lit exactly while a fault is latched
   a_led_tracks_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5] == (rsp_tdata[1:0] != psfl_pkg::FAULT_NONE)))
      else $error("fault LED disagrees with latched fault code");

   // servo can only be enabled with no fault latched
   a_servo_no_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |-> (rsp_tdata[1:0] == psfl_pkg::FAULT_NONE))
      else $error("servo enabled while a fault is latched");

   // a new trip leaves a fault latched and the servo off
   a_trip_latches: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2])
         |-> ((rsp_tdata[1:0] != psfl_pkg::FAULT_NONE) && !rsp_tdata[4]))
      else $error("trip reported without a latched fault");

   // an overcurrent sample always leaves some fault latched
   a_oc_event_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_tdata[1:0] != psfl_pkg::FAULT_NONE))
      else $error("overcurrent event with no fault latched");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind power_safety_fault_latch_top psfl_checker u_psfl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
